// File: hw/rtl/asps_pkg.sv
// ----------------------------------------------------------------------------
// asps_pkg
// Shared types and constants of the averaged sensor percent scaler.
// ----------------------------------------------------------------------------
package asps_pkg;

   // batch length; a power of two so the average is a plain shift
   localparam int SAMPLES    = 8;
   localparam int NUM_CH     = 2;
   localparam int SAMPLE_W   = 12;
   localparam int PCT_W      = 7;
   localparam int SUM_W      = $clog2(SAMPLES * 4095 + 1);
   localparam int CNT_W      = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int PROD_W     = SAMPLE_W + PCT_W;
   localparam int DIV_CNT_W  = $clog2(PCT_W);
   localparam int CSR_IDX_W  = 3;

   typedef logic [SAMPLE_W-1:0]  sample_type;
   typedef logic [PCT_W-1:0]     pct_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam pct_type PCT_MAX = pct_type'(100);

   // channel codes
   localparam logic CH_LIGHT    = 1'b0;
   localparam logic CH_MOISTURE = 1'b1;

   // register indexes
   localparam csr_index_type REG_LIGHT_DARK     = csr_index_type'(0);
   localparam csr_index_type REG_LIGHT_BRIGHT   = csr_index_type'(1);
   localparam csr_index_type REG_MOISTURE_WET   = csr_index_type'(2);
   localparam csr_index_type REG_MOISTURE_DRY   = csr_index_type'(3);
   localparam csr_index_type REG_SAT_THRESHOLD  = csr_index_type'(4);
   localparam csr_index_type REG_LIGHT_ENABLE   = csr_index_type'(5);

   // register reset values
   localparam sample_type LIGHT_DARK_RESET    = sample_type'(1300);
   localparam sample_type LIGHT_BRIGHT_RESET  = sample_type'(4050);
   localparam sample_type MOISTURE_WET_RESET  = sample_type'(2100);
   localparam sample_type MOISTURE_DRY_RESET  = sample_type'(3950);
   localparam sample_type SAT_THRESHOLD_RESET = sample_type'(4090);
   localparam logic       LIGHT_ENABLE_RESET  = 1'b0;

   typedef struct packed {
      logic accumulate;  // take the accepted sample into its channel
      logic scale;       // clamp, numerator, span, flags
      logic mult;        // numerator times 100, divider init
      logic div_step;    // one quotient bit
      logic load;        // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic batch_done;  // the offered sample completes its channel's batch
      logic out_free;    // output register can take a result this cycle
   } status_type;

endpackage

// File: hw/rtl/asps_ifs.sv
// ----------------------------------------------------------------------------
// asps channel interfaces
// Sample request, result response and register write channels.
// ----------------------------------------------------------------------------
interface asps_req_if;
   import asps_pkg::*;
   logic       valid;
   logic       ready;
   logic       sensor_channel;
   sample_type sample_value;
   modport source (output valid, sensor_channel, sample_value, input ready);
   modport sink   (input valid, sensor_channel, sample_value, output ready);
endinterface

interface asps_rsp_if;
   import asps_pkg::*;
   logic       valid;
   logic       ready;
   logic       result_channel;
   sample_type average_level;
   pct_type    level_percent;
   logic       near_saturation;
   modport source (output valid, result_channel, average_level, level_percent,
                   near_saturation, input ready);
   modport sink   (input valid, result_channel, average_level, level_percent,
                   near_saturation, output ready);
endinterface

interface asps_csr_if;
   import asps_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type reg_index;
   sample_type    write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// File: hw/rtl/asps_datapath.sv
// ----------------------------------------------------------------------------
// asps_datapath
// Channel accumulators, settings registers, scaling, serial divider and
// output register.
// ----------------------------------------------------------------------------
module asps_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  asps_pkg::cmd_type      cmd,
   output asps_pkg::status_type   status,
   input  logic                   req_sensor_channel,
   input  asps_pkg::sample_type   req_sample_value,
   input  logic                   csr_valid,
   input  asps_pkg::csr_index_type csr_reg_index,
   input  asps_pkg::sample_type   csr_write_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_result_channel,
   output asps_pkg::sample_type   rsp_average_level,
   output asps_pkg::pct_type      rsp_level_percent,
   output logic                   rsp_near_saturation
);
   import asps_pkg::*;

   // settings
   sample_type dark_ff, dark_in, bright_ff, bright_in, wet_ff, wet_in;
   sample_type dry_ff, dry_in, thresh_ff, thresh_in;
   logic       light_en_ff, light_en_in;

   // accumulators
   logic [SUM_W-1:0] sum_ff   [NUM_CH];
   logic [SUM_W-1:0] sum_in   [NUM_CH];
   logic [CNT_W-1:0] count_ff [NUM_CH];
   logic [CNT_W-1:0] count_in [NUM_CH];
   logic [SUM_W-1:0] sum_next;
   logic             sel;

   // batch result in flight
   logic       chan_ff, chan_in;
   sample_type avg_ff, avg_in;
   sample_type num_ff, num_in, span_ff, span_in;
   logic       zero_pct_ff, zero_pct_in, force_ff, force_in, sat_ff, sat_in;
   sample_type lo, hi, clamped;

   // divider
   logic [PROD_W-1:0]   prod;
   sample_type          rem_ff, rem_in;
   pct_type             low_ff, low_in, quo_ff, quo_in;
   logic [SAMPLE_W:0]   trial, span_ext;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic       out_chan_ff, out_chan_in;
   sample_type out_avg_ff, out_avg_in;
   pct_type    out_pct_ff, out_pct_in;
   logic       out_sat_ff, out_sat_in;

   always_comb begin
      sel               = req_sensor_channel;
      sum_next          = sum_ff[sel] + SUM_W'(req_sample_value);
      status.batch_done = (count_ff[sel] == CNT_W'(SAMPLES - 1));
      status.out_free   = !out_valid_ff || rsp_ready;
   end

   // settings writes; unknown indexes are dropped
   always_comb begin
      dark_in     = dark_ff;
      bright_in   = bright_ff;
      wet_in      = wet_ff;
      dry_in      = dry_ff;
      thresh_in   = thresh_ff;
      light_en_in = light_en_ff;
      if (csr_valid) begin
         case (csr_reg_index)
            REG_LIGHT_DARK:    dark_in     = csr_write_data;
            REG_LIGHT_BRIGHT:  bright_in   = csr_write_data;
            REG_MOISTURE_WET:  wet_in      = csr_write_data;
            REG_MOISTURE_DRY:  dry_in      = csr_write_data;
            REG_SAT_THRESHOLD: thresh_in   = csr_write_data;
            REG_LIGHT_ENABLE:  light_en_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      chan_in  = chan_ff;
      avg_in   = avg_ff;
      if (cmd.accumulate) begin
         if (status.batch_done) begin
            sum_in[sel]   = '0;
            count_in[sel] = '0;
            avg_in        = SAMPLE_W'(sum_next / SAMPLES);
            chan_in       = sel;
         end else begin
            sum_in[sel]   = sum_next;
            count_in[sel] = count_ff[sel] + CNT_W'(1);
         end
      end
   end

   // clamp and span; results of an empty span are masked at the output
   always_comb begin
      lo          = (chan_ff == CH_MOISTURE) ? wet_ff : dark_ff;
      hi          = (chan_ff == CH_MOISTURE) ? dry_ff : bright_ff;
      clamped     = (avg_ff < lo) ? lo : ((avg_ff > hi) ? hi : avg_ff);
      num_in      = num_ff;
      span_in     = span_ff;
      zero_pct_in = zero_pct_ff;
      force_in    = force_ff;
      sat_in      = sat_ff;
      if (cmd.scale) begin
         force_in    = (chan_ff == CH_LIGHT) && !light_en_ff;
         num_in      = (chan_ff == CH_MOISTURE) ? hi - clamped : clamped - lo;
         span_in     = hi - lo;
         zero_pct_in = !(hi > lo) || force_in;
         sat_in      = (avg_ff >= thresh_ff) && !force_in;
      end
   end

   // restoring division of num*100 by span; quotient fits PCT_W bits since
   // num <= span, so the top bits of the product start below the divisor
   always_comb begin
      prod     = PROD_W'(num_ff) * PROD_W'(PCT_MAX);
      span_ext = {1'b0, span_ff};
      trial    = {rem_ff, low_ff[PCT_W-1]};
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      if (cmd.mult) begin
         rem_in = prod[PROD_W-1:PCT_W];
         low_in = prod[PCT_W-1:0];
         quo_in = '0;
      end else if (cmd.div_step) begin
         low_in = low_ff << 1;
         if (trial >= span_ext) begin
            rem_in = SAMPLE_W'(trial - span_ext);
            quo_in = {quo_ff[PCT_W-2:0], 1'b1};
         end else begin
            rem_in = SAMPLE_W'(trial);
            quo_in = {quo_ff[PCT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_chan_in  = out_chan_ff;
      out_avg_in   = out_avg_ff;
      out_pct_in   = out_pct_ff;
      out_sat_in   = out_sat_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
         out_chan_in  = chan_ff;
         out_avg_in   = force_ff ? '0 : avg_ff;
         out_pct_in   = zero_pct_ff ? '0 : ((quo_ff > PCT_MAX) ? PCT_MAX : quo_ff);
         out_sat_in   = sat_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff      <= LIGHT_DARK_RESET;
         bright_ff    <= LIGHT_BRIGHT_RESET;
         wet_ff       <= MOISTURE_WET_RESET;
         dry_ff       <= MOISTURE_DRY_RESET;
         thresh_ff    <= SAT_THRESHOLD_RESET;
         light_en_ff  <= LIGHT_ENABLE_RESET;
         for (int i = 0; i < NUM_CH; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         dark_ff      <= dark_in;
         bright_ff    <= bright_in;
         wet_ff       <= wet_in;
         dry_ff       <= dry_in;
         thresh_ff    <= thresh_in;
         light_en_ff  <= light_en_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      avg_ff      <= avg_in;
      num_ff      <= num_in;
      span_ff     <= span_in;
      zero_pct_ff <= zero_pct_in;
      force_ff    <= force_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      out_chan_ff <= out_chan_in;
      out_avg_ff  <= out_avg_in;
      out_pct_ff  <= out_pct_in;
      out_sat_ff  <= out_sat_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_channel  = out_chan_ff;
   assign rsp_average_level   = out_avg_ff;
   assign rsp_level_percent   = out_pct_ff;
   assign rsp_near_saturation = out_sat_ff;

   // a finished batch leaves its channel's accumulator empty
   a_batch_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.accumulate && status.batch_done |=>
         count_ff[chan_ff] == '0 && sum_ff[chan_ff] == '0)
      else $error("batch completion did not clear its accumulator");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_pct_ff <= PCT_MAX)
      else $error("percent above 100 in output register");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result loaded over an untaken result");

endmodule

// File: hw/rtl/asps_controller.sv
// ----------------------------------------------------------------------------
// asps_controller
// Sequencer: takes samples, then walks a finished batch through scaling,
// the bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module asps_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  asps_pkg::status_type status,
   output asps_pkg::cmd_type    cmd
);
   import asps_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCALE  = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PCT_W - 1);

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  accept;

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      accept         = req_valid && req_ready;
      cmd.accumulate = accept;
      cmd.scale      = (state_ff == ST_SCALE);
      cmd.mult       = (state_ff == ST_MULT);
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.load       = (state_ff == ST_FINISH) && status.out_free;
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.batch_done) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_MULT;
         ST_MULT: begin
            state_in   = ST_DIVIDE;
            div_cnt_in = '0;
         end
         ST_DIVIDE: begin
            if (div_cnt_ff == DIV_LAST) state_in = ST_FINISH;
            else div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE && div_cnt_ff == DIV_LAST |=> state_ff == ST_FINISH)
      else $error("divider ran past its last quotient bit");

   a_mult_to_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MULT |=> state_ff == ST_DIVIDE && div_cnt_ff == '0)
      else $error("divider started without a cleared step count");

   a_reopen: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_ready)
      else $error("input not reopened after result load");

endmodule

// File: hw/rtl/averaged_sensor_percent_scaler_unit.sv
// ----------------------------------------------------------------------------
// averaged_sensor_percent_scaler_unit
// Per-channel 8-sample averaging of light and moisture readings with a
// clamped linear percent and a near-saturation flag.
// ----------------------------------------------------------------------------
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    sensor_channel, sample_value
//   rsp_bus   out        valid/ready    result_channel, average_level,
//                                       level_percent, near_saturation
//   csr_bus   in         valid/ready    reg_index, write_data (always ready)
//
// A sample that does not finish a batch is taken and the input stays open.
// A sample that finishes a batch holds the input off after its accept while
// the batch goes through scale, multiply, the one-bit-per-cycle divider and
// output load; the input reopens once the output load is done.
// The output register lets the next samples in while a result waits;
// a waiting result stalls only the next batch completion at output load.
// Reset restores the register defaults and empties both accumulators.
// ----------------------------------------------------------------------------
module averaged_sensor_percent_scaler_unit (
   input logic clock,
   input logic reset,
   asps_req_if.sink   req_bus,
   asps_rsp_if.source rsp_bus,
   asps_csr_if.sink   csr_bus
);
   import asps_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   asps_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   asps_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sensor_channel  (req_bus.sensor_channel),
      .req_sample_value    (req_bus.sample_value),
      .csr_valid           (csr_bus.valid),
      .csr_reg_index       (csr_bus.reg_index),
      .csr_write_data      (csr_bus.write_data),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_result_channel  (rsp_bus.result_channel),
      .rsp_average_level   (rsp_bus.average_level),
      .rsp_level_percent   (rsp_bus.level_percent),
      .rsp_near_saturation (rsp_bus.near_saturation)
   );

endmodule
